### hdl/vrefs_pkg.sv
`timescale 1ns / 1ps
package vrefs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CONN_W    = 20;
	localparam int DIR_W     = 18;
	localparam int ND_W      = 52;  // dir . offset, exact
	localparam int NUM_W     = 68;  // 2*(|o|^2/2 - h.o), exact
	localparam int QUOT_W    = 31;
	localparam int QCNT_W    = 5;

	localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		CFG_DIR_X  = 3'd0,
		CFG_DIR_Y  = 3'd1,
		CFG_DIR_Z  = 3'd2,
		CFG_HEAD_X = 3'd3,
		CFG_HEAD_Y = 3'd4,
		CFG_HEAD_Z = 3'd5,
		CFG_TOL    = 3'd6,
		CFG_NONE   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic [31:0]        face_area;
		logic [19:0]        connection_id;
		logic               neighbour_removed;
		logic               last_in_cell;
	} in_word_t;

	typedef struct packed {
		logic               exit_found;
		logic [19:0]        exit_connection;
		logic signed [31:0] exit_distance;
		logic signed [31:0] exit_offset_x;
		logic signed [31:0] exit_offset_y;
		logic signed [31:0] exit_offset_z;
	} out_word_t;

	typedef struct packed {
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic signed [17:0] dir_z;
		logic signed [31:0] head_x;
		logic signed [31:0] head_y;
		logic signed [31:0] head_z;
		logic [30:0]        tol;
	} cfg_t;

	// one classified neighbour, front to back
	typedef struct packed {
		logic                    cand;
		logic                    last;
		logic signed [NUM_W-1:0] num;
		logic [ND_W-1:0]         den;
		logic signed [31:0]      offset_x;
		logic signed [31:0]      offset_y;
		logic signed [31:0]      offset_z;
		logic [31:0]             area;
		logic [19:0]             id;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_UPD,
		B_FIN
	} back_state_t;

endpackage

### hdl/voronoi_ray_exit_face_select_top.sv
`timescale 1ns / 1ps
// Exit-face selector for a ray crossing one Voronoi cell. Push the cell's
// neighbours one word at a time; after the word marked last, one result word
// appears (found flag, connection, Q15.16 distance, offset). The front takes a
// word and forms dir.o and the crossing numerator on one shared 32x32
// multiplier, so it takes no new word until it has passed the last one on (a
// removed neighbour skips the multiplier). The back runs a 31-step restoring
// divider for forward-facing neighbours; it takes the word, divides, compares
// and updates, and finishes, and skips the divide and update for any other.
// A two-word queue between them lets the front work on the next neighbour
// while the back divides. Configuration words take effect at once; the user
// must write them only while the block is idle; the block does not enforce it.
module voronoi_ray_exit_face_select_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  vrefs_pkg::in_word_t  item,
	output logic                 empty,
	input  logic                 pop,
	output vrefs_pkg::out_word_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	vrefs_pkg::cfg_t cfg_q;
	vrefs_pkg::job_t fj, bj;
	logic            fj_push, fj_full, bj_pop, bj_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dir_x  <= 18'sd1 <<< vrefs_pkg::FRAC_BITS;
			cfg_q.dir_y  <= '0;
			cfg_q.dir_z  <= '0;
			cfg_q.head_x <= '0;
			cfg_q.head_y <= '0;
			cfg_q.head_z <= '0;
			cfg_q.tol    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vrefs_pkg::cfg_idx_t'(cfg_index))
				vrefs_pkg::CFG_DIR_X:  cfg_q.dir_x  <= cfg_data[17:0];
				vrefs_pkg::CFG_DIR_Y:  cfg_q.dir_y  <= cfg_data[17:0];
				vrefs_pkg::CFG_DIR_Z:  cfg_q.dir_z  <= cfg_data[17:0];
				vrefs_pkg::CFG_HEAD_X: cfg_q.head_x <= cfg_data;
				vrefs_pkg::CFG_HEAD_Y: cfg_q.head_y <= cfg_data;
				vrefs_pkg::CFG_HEAD_Z: cfg_q.head_z <= cfg_data;
				vrefs_pkg::CFG_TOL:    cfg_q.tol    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	vrefs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.job_push (fj_push),
		.job      (fj),
		.job_full (fj_full)
	);

	vrefs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fj_push),
		.wr_data (fj),
		.full    (fj_full),
		.rd_en   (bj_pop),
		.rd_data (bj),
		.empty   (bj_empty)
	);

	vrefs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (bj),
		.job_empty (bj_empty),
		.job_pop   (bj_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

### hdl/vrefs_fifo.sv
`timescale 1ns / 1ps
module vrefs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  vrefs_pkg::job_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output vrefs_pkg::job_t rd_data,
	output logic            empty
);

	vrefs_pkg::job_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) wp_q <= ~wp_q;
			if (rd_en && !empty) rp_q <= ~rp_q;
			unique case ({wr_en && !full, rd_en && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

endmodule

### hdl/vrefs_front.sv
`timescale 1ns / 1ps
module vrefs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  vrefs_pkg::cfg_t    cfg,
	input  logic               push,
	input  vrefs_pkg::in_word_t item,
	output logic               full,
	output logic               job_push,
	output vrefs_pkg::job_t    job,
	input  logic               job_full
);

	vrefs_pkg::front_state_t st_q, st_d;
	vrefs_pkg::in_word_t     item_q;
	logic [3:0]              cnt_q;
	logic [3:0]              ptag_q;
	logic signed [63:0]      p_q;
	logic signed [vrefs_pkg::ND_W-1:0]  nd_q;
	logic signed [vrefs_pkg::NUM_W-1:0] num_q;
	logic signed [31:0]      ma, mb;
	logic                    take;

	assign take = push && !full;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vrefs_pkg::F_IDLE: begin
				if (take) st_d = item.neighbour_removed ? vrefs_pkg::F_PUSH : vrefs_pkg::F_MUL;
			end
			vrefs_pkg::F_MUL: begin
				if (cnt_q == 4'd9) st_d = vrefs_pkg::F_PUSH;
			end
			vrefs_pkg::F_PUSH: begin
				if (!job_full) st_d = vrefs_pkg::F_IDLE;
			end
			default: st_d = vrefs_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		full     = st_q != vrefs_pkg::F_IDLE;
		job_push = st_q == vrefs_pkg::F_PUSH;
		job.cand     = nd_q > 0;
		job.last     = item_q.last_in_cell;
		job.num      = num_q;
		job.den      = {nd_q[vrefs_pkg::ND_W-2:0], 1'b0};
		job.offset_x = item_q.offset_x;
		job.offset_y = item_q.offset_y;
		job.offset_z = item_q.offset_z;
		job.area     = item_q.face_area;
		job.id       = item_q.connection_id;
	end

	// one shared multiplier: three d.o terms, three o.o terms, three h.o terms
	always_comb begin
		unique case (cnt_q)
			4'd0: begin ma = 32'(cfg.dir_x); mb = item_q.offset_x; end
			4'd1: begin ma = 32'(cfg.dir_y); mb = item_q.offset_y; end
			4'd2: begin ma = 32'(cfg.dir_z); mb = item_q.offset_z; end
			4'd3: begin ma = item_q.offset_x; mb = item_q.offset_x; end
			4'd4: begin ma = item_q.offset_y; mb = item_q.offset_y; end
			4'd5: begin ma = item_q.offset_z; mb = item_q.offset_z; end
			4'd6: begin ma = cfg.head_x; mb = item_q.offset_x; end
			4'd7: begin ma = cfg.head_y; mb = item_q.offset_y; end
			4'd8: begin ma = cfg.head_z; mb = item_q.offset_z; end
			default: begin ma = 32'sd0; mb = 32'sd0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= vrefs_pkg::F_IDLE;
			cnt_q <= 4'd0;
		end else begin
			st_q <= st_d;
			if (st_q == vrefs_pkg::F_MUL) cnt_q <= cnt_q + 4'd1;
			else cnt_q <= 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
			nd_q   <= '0;
			num_q  <= '0;
		end
		if (st_q == vrefs_pkg::F_MUL) begin
			p_q    <= ma * mb;
			ptag_q <= cnt_q;
			if (cnt_q != 4'd0) begin
				unique case (ptag_q)
					4'd0, 4'd1, 4'd2:
						nd_q <= nd_q + p_q[vrefs_pkg::ND_W-1:0];
					4'd3, 4'd4, 4'd5:
						num_q <= num_q + vrefs_pkg::NUM_W'(p_q);
					default:
						num_q <= num_q - (vrefs_pkg::NUM_W'(p_q) <<< 1);
				endcase
			end
		end
	end

endmodule

### hdl/vrefs_back.sv
`timescale 1ns / 1ps
module vrefs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vrefs_pkg::cfg_t      cfg,
	input  vrefs_pkg::job_t      job,
	input  logic                 job_empty,
	output logic                 job_pop,
	output logic                 empty,
	input  logic                 pop,
	output vrefs_pkg::out_word_t result
);

	vrefs_pkg::back_state_t st_q, st_d;
	vrefs_pkg::job_t        job_q;
	logic [vrefs_pkg::ND_W-1:0]   rem_q;
	logic [vrefs_pkg::QUOT_W-1:0] lo_q;
	logic [vrefs_pkg::QUOT_W-1:0] quo_q;
	logic [vrefs_pkg::QCNT_W-1:0] dcnt_q;
	logic                   ovf_q;
	logic                   neg_q;

	logic                   best_valid_q;
	logic signed [31:0]     best_dist_q;
	logic [19:0]            best_conn_q;
	logic [31:0]            best_area_q;
	logic signed [31:0]     best_ox_q, best_oy_q, best_oz_q;

	vrefs_pkg::out_word_t   out_q;
	logic                   out_v_q;

	logic [vrefs_pkg::NUM_W-1:0] mag;
	logic [vrefs_pkg::ND_W-1:0]  hi;
	logic [vrefs_pkg::ND_W:0]    rsh;
	logic                        rge;
	logic signed [31:0]          t;
	logic signed [33:0]          lo_b, hi_b, t_e;
	logic                        take_new, take_tie;
	logic                        emit;

	assign empty  = !out_v_q;
	assign result = out_q;

	assign mag = job.num[vrefs_pkg::NUM_W-1] ? -job.num : job.num;
	// top of |num| << FRAC_BITS, above the QUOT_W quotient bits
	assign hi  = mag[vrefs_pkg::NUM_W-2:vrefs_pkg::QUOT_W-vrefs_pkg::FRAC_BITS];
	assign rsh = {rem_q, lo_q[vrefs_pkg::QUOT_W-1]};
	assign rge = rsh >= {1'b0, job_q.den};

	always_comb begin
		if (neg_q) t = ovf_q ? vrefs_pkg::DIST_MIN : -$signed({1'b0, quo_q});
		else       t = ovf_q ? vrefs_pkg::DIST_MAX : $signed({1'b0, quo_q});
		t_e  = 34'(t);
		lo_b = 34'(best_dist_q) - $signed({3'b0, cfg.tol});
		hi_b = 34'(best_dist_q) + $signed({3'b0, cfg.tol});
		take_new = !best_valid_q || (t_e < lo_b);
		take_tie = !take_new && (t_e < hi_b) && (job_q.area > best_area_q);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vrefs_pkg::B_IDLE: begin
				if (!job_empty) st_d = job.cand ? vrefs_pkg::B_DIV : vrefs_pkg::B_FIN;
			end
			vrefs_pkg::B_DIV: begin
				if (dcnt_q == vrefs_pkg::QCNT_W'(vrefs_pkg::QUOT_W - 1)) st_d = vrefs_pkg::B_UPD;
			end
			vrefs_pkg::B_UPD: st_d = vrefs_pkg::B_FIN;
			vrefs_pkg::B_FIN: begin
				if (!job_q.last || !out_v_q) st_d = vrefs_pkg::B_IDLE;
			end
			default: st_d = vrefs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (st_q == vrefs_pkg::B_IDLE) && !job_empty;
		emit    = (st_q == vrefs_pkg::B_FIN) && job_q.last && !out_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= vrefs_pkg::B_IDLE;
			dcnt_q       <= '0;
			out_v_q      <= 1'b0;
			best_valid_q <= 1'b0;
			best_dist_q  <= vrefs_pkg::DIST_MAX;
			best_conn_q  <= '0;
			best_area_q  <= '0;
			best_ox_q    <= '0;
			best_oy_q    <= '0;
			best_oz_q    <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == vrefs_pkg::B_DIV) dcnt_q <= dcnt_q + vrefs_pkg::QCNT_W'(1);
			else dcnt_q <= '0;
			if (emit) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			if (st_q == vrefs_pkg::B_UPD && (take_new || take_tie)) begin
				best_valid_q <= 1'b1;
				best_dist_q  <= (take_tie && best_dist_q < t) ? best_dist_q : t;
				best_conn_q  <= job_q.id;
				best_area_q  <= job_q.area;
				best_ox_q    <= job_q.offset_x;
				best_oy_q    <= job_q.offset_y;
				best_oz_q    <= job_q.offset_z;
			end
			if (emit) begin
				best_valid_q <= 1'b0;
				best_dist_q  <= vrefs_pkg::DIST_MAX;
				best_conn_q  <= '0;
				best_area_q  <= '0;
				best_ox_q    <= '0;
				best_oy_q    <= '0;
				best_oz_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			neg_q <= job.num[vrefs_pkg::NUM_W-1];
			ovf_q <= hi >= job.den;
			rem_q <= hi;
			lo_q  <= {mag[vrefs_pkg::QUOT_W-vrefs_pkg::FRAC_BITS-1:0],
				{vrefs_pkg::FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end
		// restoring divide, one quotient bit a cycle
		if (st_q == vrefs_pkg::B_DIV) begin
			rem_q <= rge ? vrefs_pkg::ND_W'(rsh - {1'b0, job_q.den})
				: rsh[vrefs_pkg::ND_W-1:0];
			lo_q  <= {lo_q[vrefs_pkg::QUOT_W-2:0], 1'b0};
			quo_q <= {quo_q[vrefs_pkg::QUOT_W-2:0], rge};
		end
		if (emit) begin
			out_q.exit_found      <= best_valid_q;
			out_q.exit_connection <= best_conn_q;
			out_q.exit_distance   <= best_dist_q;
			out_q.exit_offset_x   <= best_ox_q;
			out_q.exit_offset_y   <= best_oy_q;
			out_q.exit_offset_z   <= best_oz_q;
		end
	end

endmodule

### test/exit_face_checker.sv
`timescale 1ns / 1ps
module exit_face_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  vrefs_pkg::in_word_t  item,
	input  logic                 empty,
	input  logic                 pop,
	input  vrefs_pkg::out_word_t result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);

	logic signed [17:0] ray_dir [3];
	logic signed [31:0] ray_head [3];
	logic [30:0]        tie_tol;

	logic               best_found;
	longint             best_dist;
	logic [19:0]        best_conn;
	logic [31:0]        best_area;
	logic signed [31:0] best_ofs [3];

	vrefs_pkg::out_word_t exit_q [$];

	function automatic longint crossing_distance(input logic signed [31:0] o [3],
			input longint nd);
		logic signed [127:0] acc;
		logic signed [127:0] ow;
		logic signed [127:0] hw;
		logic [127:0]        mag;
		logic [127:0]        q;
		logic                neg;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			ow = o[k];
			hw = ray_head[k];
			acc = acc + ow * ow - 2 * hw * ow;
		end
		neg = acc < 0;
		mag = neg ? -acc : acc;
		mag = mag << vrefs_pkg::FRAC_BITS;
		q = mag / (128'(nd) * 2);
		if (!neg)
			return (q > 128'(vrefs_pkg::DIST_MAX)) ? longint'(vrefs_pkg::DIST_MAX)
				: longint'(q);
		if (q >= 128'h8000_0000)
			return longint'(vrefs_pkg::DIST_MIN);
		return -longint'(q);
	endfunction

	task automatic clear_cell();
		best_found = 1'b0;
		best_dist  = longint'(vrefs_pkg::DIST_MAX);
		best_conn  = '0;
		best_area  = '0;
		for (int k = 0; k < 3; k++)
			best_ofs[k] = '0;
	endtask

	task automatic take_face(input longint t, input vrefs_pkg::in_word_t w);
		best_found  = 1'b1;
		best_dist   = t;
		best_conn   = w.connection_id;
		best_area   = w.face_area;
		best_ofs[0] = w.offset_x;
		best_ofs[1] = w.offset_y;
		best_ofs[2] = w.offset_z;
	endtask

	task automatic accept_neighbour(input vrefs_pkg::in_word_t w);
		logic signed [31:0]   o [3];
		longint               nd;
		longint               t;
		longint               tl;
		vrefs_pkg::out_word_t r;
		o[0] = w.offset_x;
		o[1] = w.offset_y;
		o[2] = w.offset_z;
		tl = longint'(tie_tol);
		if (!w.neighbour_removed) begin
			nd = 0;
			for (int k = 0; k < 3; k++)
				nd += longint'(ray_dir[k]) * longint'(o[k]);
			if (nd > 0) begin
				t = crossing_distance(o, nd);
				if (!best_found || t < best_dist - tl)
					take_face(t, w);
				else if (t < best_dist + tl && w.face_area > best_area)
					take_face((t < best_dist) ? t : best_dist, w);
			end
		end
		if (w.last_in_cell) begin
			r.exit_found      = best_found;
			r.exit_connection = best_conn;
			r.exit_distance   = 32'(best_dist);
			r.exit_offset_x   = best_ofs[0];
			r.exit_offset_y   = best_ofs[1];
			r.exit_offset_z   = best_ofs[2];
			exit_q.push_back(r);
			clear_cell();
		end
	endtask

	task automatic check_exit(input vrefs_pkg::out_word_t got);
		vrefs_pkg::out_word_t e;
		if (exit_q.size() == 0) begin
			$error("unexpected result word");
			errors++;
			return;
		end
		e = exit_q.pop_front();
		if (got.exit_found !== e.exit_found) begin
			$error("exit_found exp %0d got %0d", e.exit_found, got.exit_found);
			errors++;
		end
		if (got.exit_connection !== e.exit_connection) begin
			$error("exit_connection exp %0h got %0h", e.exit_connection, got.exit_connection);
			errors++;
		end
		if (got.exit_distance !== e.exit_distance) begin
			$error("exit_distance exp %0d got %0d", e.exit_distance, got.exit_distance);
			errors++;
		end
		if (got.exit_offset_x !== e.exit_offset_x) begin
			$error("exit_offset_x exp %0d got %0d", e.exit_offset_x, got.exit_offset_x);
			errors++;
		end
		if (got.exit_offset_y !== e.exit_offset_y) begin
			$error("exit_offset_y exp %0d got %0d", e.exit_offset_y, got.exit_offset_y);
			errors++;
		end
		if (got.exit_offset_z !== e.exit_offset_z) begin
			$error("exit_offset_z exp %0d got %0d", e.exit_offset_z, got.exit_offset_z);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_dir[0]  = 18'sd65536;
			ray_dir[1]  = '0;
			ray_dir[2]  = '0;
			for (int k = 0; k < 3; k++)
				ray_head[k] = '0;
			tie_tol = '0;
			clear_cell();
			exit_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (vrefs_pkg::cfg_idx_t'(cfg_index))
					vrefs_pkg::CFG_DIR_X:  ray_dir[0]  = cfg_data[17:0];
					vrefs_pkg::CFG_DIR_Y:  ray_dir[1]  = cfg_data[17:0];
					vrefs_pkg::CFG_DIR_Z:  ray_dir[2]  = cfg_data[17:0];
					vrefs_pkg::CFG_HEAD_X: ray_head[0] = cfg_data;
					vrefs_pkg::CFG_HEAD_Y: ray_head[1] = cfg_data;
					vrefs_pkg::CFG_HEAD_Z: ray_head[2] = cfg_data;
					vrefs_pkg::CFG_TOL:    tie_tol     = cfg_data[30:0];
					default: ;
				endcase
			end
			if (pop && !empty)
				check_exit(result);
			if (push && !full)
				accept_neighbour(item);
			pending = exit_q.size();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	vrefs_pkg::in_word_t  item;
	logic                 empty;
	logic                 pop;
	vrefs_pkg::out_word_t result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           cfg_index;
	logic [31:0]          cfg_data;
	int                   errors;
	int                   pending;
	vrefs_pkg::in_word_t  prev_word;

	voronoi_ray_exit_face_select_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	exit_face_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 32'($signed($urandom_range(0, 262143)) - 131072);
		if (r < 9) return 32'($signed($urandom_range(0, 2097151)) - 1048576);
		return $urandom;
	endfunction

	function automatic vrefs_pkg::in_word_t neighbour(input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] area,
			input logic [19:0] id, input logic removed, input logic last);
		vrefs_pkg::in_word_t w;
		w.offset_x = x;
		w.offset_y = y;
		w.offset_z = z;
		w.face_area = area;
		w.connection_id = id;
		w.neighbour_removed = removed;
		w.last_in_cell = last;
		return w;
	endfunction

	task automatic send_word(input vrefs_pkg::in_word_t w);
		int g;
		@(negedge clk);
		push = 1'b1;
		item = w;
		do @(posedge clk); while (full);
		prev_word = w;
		g = idle_len();
		if (g > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input vrefs_pkg::cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// hold until all results are out and the pipe has drained
	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic random_cell();
		int n;
		logic [31:0] area;
		vrefs_pkg::in_word_t w;
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			area = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
			w = neighbour(coord(), coord(), coord(), area, 20'($urandom),
				$urandom_range(0, 9) == 0, k == n - 1);
			// repeat a face now and then to provoke ties
			if (k > 0 && $urandom_range(0, 4) == 0) begin
				w.offset_x = prev_word.offset_x;
				w.offset_y = prev_word.offset_y;
				w.offset_z = prev_word.offset_z + 32'($urandom_range(0, 3));
			end
			// noise: a stray last flag breaks the cell early
			if ($urandom_range(0, 29) == 0)
				w.last_in_cell = 1'b1;
			send_word(w);
		end
	endtask

	task automatic set_phase(input int p);
		logic [31:0] v;
		for (int k = 0; k < 3; k++) begin
			case (p % 4)
				0: v = ($urandom_range(0, 1) == 0) ? 32'hFFFF_0000 : 32'h0001_0000;
				1: v = 32'($signed($urandom_range(0, 131072)) - 65536);
				2: v = 32'($signed($urandom_range(0, 2047)) - 1024);
				default: v = (k == 0) ? 32'h0000_B505 : ((k == 1) ? 32'hFFFF_4AFB : 32'h0);
			endcase
			write_reg(vrefs_pkg::cfg_idx_t'(vrefs_pkg::CFG_DIR_X + k), v);
		end
		for (int k = 0; k < 3; k++) begin
			case (p % 3)
				0: v = 32'h0;
				1: v = 32'($signed($urandom_range(0, 524287)) - 262144);
				default: v = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
			write_reg(vrefs_pkg::cfg_idx_t'(vrefs_pkg::CFG_HEAD_X + k), v);
		end
		case (p % 3)
			0: v = 32'h0;
			1: v = $urandom_range(0, 65536);
			default: v = 32'h7FFF_FFFF;
		endcase
		write_reg(vrefs_pkg::CFG_TOL, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = vrefs_pkg::CFG_DIR_X;
		cfg_data = '0;
		prev_word = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset ray: +x from the generator
		send_word(neighbour(32'h0002_0000, 32'h0, 32'h0, 32'd5, 20'd1, 1'b0, 1'b0));
		send_word(neighbour(32'h0002_0000, 32'h0, 32'h0, 32'd9, 20'd2, 1'b0, 1'b0));
		send_word(neighbour(32'h0001_0000, 32'h0001_0000, 32'h0, 32'd3, 20'd3, 1'b1, 1'b1));
		send_word(neighbour(32'hFFFF_0000, 32'h0, 32'h0, 32'd7, 20'd4, 1'b0, 1'b1));
		send_word(neighbour(32'h0, 32'h0003_0000, 32'h0, 32'd7, 20'd5, 1'b0, 1'b1));
		send_word(neighbour(32'h0, 32'h0, 32'h0, 32'd0, 20'd0, 1'b0, 1'b1));
		send_word(neighbour(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 20'hFFFFF, 1'b0, 1'b1));
		send_word(neighbour(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 20'd6,
			1'b0, 1'b0));
		send_word(neighbour(32'h0004_0000, 32'h0, 32'h0, 32'd0, 20'd7, 1'b0, 1'b1));
		send_word(neighbour(32'h0003_0000, 32'h0001_0000, 32'h0, 32'd2, 20'd8, 1'b0, 1'b0));
		send_word(neighbour(32'h0003_0000, 32'hFFFF_0000, 32'h0, 32'd4, 20'd9, 1'b0, 1'b1));
		send_word(neighbour(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd0, 20'hAAAAA,
			1'b1, 1'b1));
		drain();

		// head far ahead: negative distances, then wide tolerance ties
		write_reg(vrefs_pkg::CFG_HEAD_X, 32'h7FFF_FFFF);
		write_reg(vrefs_pkg::CFG_TOL, 32'h7FFF_FFFF);
		@(negedge clk);
		cfg_valid = 1'b0;
		send_word(neighbour(32'h0001_0000, 32'h0, 32'h0, 32'd1, 20'd10, 1'b0, 1'b0));
		send_word(neighbour(32'h0002_0000, 32'h0005_0000, 32'h0, 32'd8, 20'd11, 1'b0, 1'b0));
		send_word(neighbour(32'h0000_0100, 32'h0, 32'h0, 32'd2, 20'd12, 1'b0, 1'b1));
		drain();

		for (int p = 0; p < 10; p++) begin
			set_phase(p);
			for (int c = 0; c < 22; c++) begin
				random_cell();
				if (p == 4 && c == 10) drain();
			end
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop = 1'b0;
			repeat (idle_len()) @(negedge clk);
			pop = 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
